/* src/tcc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared constants, request codes and controller/datapath handshake types
// for the text console cursor engine.
// ---------------------------------------------------------------------------
package tcc_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int CELL_N   = ROWS * COLS;
  localparam int SCROLL_N = (ROWS - 1) * COLS;
  localparam int ADDR_W   = $clog2(CELL_N);

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7e;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam int                TAB_STEP = 4;

  typedef struct packed {
    logic latch;        // capture the accepted word
    logic scroll_step;  // read row below; the copy write follows in the next cycle
    logic fill_step;    // write one space
    logic scroll_fix;   // row becomes ROWS-1
    logic put_exec;     // handle the put byte
    logic home;         // cursor to 0,0
    logic read_cell;    // read the requested cell
    logic load_out;     // load the result register
  } tcc_cmd_t;

  typedef struct packed {
    logic       row_full;
    logic       scroll_last;
    logic       fill_last;
    logic       out_free;
  } tcc_stat_t;

endpackage
`default_nettype wire

/* src/text_console_cursor_engine.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_cursor_engine
// 80x25 character store with a cursor; put, clear and read requests.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries one request word:
// req_type, char_code and the cell row/column for reads. Every request
// returns exactly one word on the output channel (out_valid/out_stall):
// the cell character for reads (zero otherwise) and the cursor afterwards.
// One request is handled at a time; in_stall is low only when idle.
// A put passes through the put step, a read through the read step, and an
// unknown code goes straight to the final step. A put with a scroll pending
// first copies the rows up, one character per cycle through the store's single
// write port. Clear writes one space per cycle into every cell.
// After reset the store is filled with spaces while in_stall stays high;
// the cursor starts at column 0, row 0.
// The result sits in an output register; while out_stall is high it holds
// and the next request waits in its final step until the register frees.
// ---------------------------------------------------------------------------
module text_console_cursor_engine (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [1:0]                  in_req_type,
  input  wire [tcc_pkg::CHAR_W-1:0]  in_char_code,
  input  wire [tcc_pkg::ROW_W-1:0]   in_cell_row,
  input  wire [tcc_pkg::COL_W-1:0]   in_cell_col,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [tcc_pkg::CHAR_W-1:0] out_cell_char,
  output logic [tcc_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tcc_pkg::ROW_W-1:0]  out_cursor_row
);

  tcc_pkg::tcc_cmd_t  cmd;
  tcc_pkg::tcc_stat_t stat;

  tcc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  tcc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_char  (out_cell_char),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row)
  );

endmodule
`default_nettype wire

/* src/tcc_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: store init after reset, request decode, scroll copy, clear
// fill, put handling and result hand-off.
// ---------------------------------------------------------------------------
module tcc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire [1:0]         in_req_type,
  input  tcc_pkg::tcc_stat_t stat,
  output tcc_pkg::tcc_cmd_t  cmd
);

  localparam logic [2:0] ST_INIT       = 3'd0;
  localparam logic [2:0] ST_IDLE       = 3'd1;
  localparam logic [2:0] ST_SCROLL     = 3'd2;
  localparam logic [2:0] ST_SCROLL_END = 3'd3;
  localparam logic [2:0] ST_PUT        = 3'd4;
  localparam logic [2:0] ST_CLEAR      = 3'd5;
  localparam logic [2:0] ST_READ       = 3'd6;
  localparam logic [2:0] ST_FINISH     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          case (in_req_type)
            tcc_pkg::REQ_PUT:   state_nxt = stat.row_full ? ST_SCROLL : ST_PUT;
            tcc_pkg::REQ_CLEAR: state_nxt = ST_CLEAR;
            tcc_pkg::REQ_READ:  state_nxt = ST_READ;
            default:            state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (stat.scroll_last) state_nxt = ST_SCROLL_END;
      end
      ST_SCROLL_END: begin
        // last copy write lands here
        cmd.scroll_fix = 1'b1;
        state_nxt      = ST_PUT;
      end
      ST_PUT: begin
        cmd.put_exec = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.home  = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.read_cell = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tcc_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_datapath
// Character store, cursor registers, sweep counter, request registers and
// the result register.
// ---------------------------------------------------------------------------
module tcc_datapath (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tcc_pkg::tcc_cmd_t            cmd,
  output tcc_pkg::tcc_stat_t           stat,
  input  wire [1:0]                    in_req_type,
  input  wire [tcc_pkg::CHAR_W-1:0]    in_char_code,
  input  wire [tcc_pkg::ROW_W-1:0]     in_cell_row,
  input  wire [tcc_pkg::COL_W-1:0]     in_cell_col,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [tcc_pkg::CHAR_W-1:0]   out_cell_char,
  output logic [tcc_pkg::COL_W-1:0]    out_cursor_col,
  output logic [tcc_pkg::ROW_W-1:0]    out_cursor_row
);

  localparam int AW = tcc_pkg::ADDR_W;
  localparam int CW = tcc_pkg::COL_W;
  localparam int RW = tcc_pkg::ROW_W;
  localparam int DW = tcc_pkg::CHAR_W;

  logic [DW-1:0] mem [tcc_pkg::CELL_N];
  logic [DW-1:0] rd_data_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] cnt_r;
  logic          cp_wr_r;
  logic [AW-1:0] cp_addr_r;

  logic [1:0]    req_r;
  logic [DW-1:0] code_r;
  logic [AW-1:0] rd_addr_r;
  logic          in_range_r;

  logic          out_valid_r;
  logic [DW-1:0] out_cell_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;

  logic          printable;
  logic [CW:0]   col_inc;
  logic [CW:0]   col_tab;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  assign stat.row_full    = (row_r == RW'(tcc_pkg::ROWS));
  assign stat.scroll_last = (cnt_r == AW'(tcc_pkg::SCROLL_N - 1));
  assign stat.fill_last   = (cnt_r == AW'(tcc_pkg::CELL_N - 1));
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign printable = (code_r >= tcc_pkg::CH_SPACE) && (code_r <= tcc_pkg::CH_TILDE);
  assign col_inc   = {1'b0, col_r} + (CW+1)'(1);
  assign col_tab   = {1'b0, col_r} + (CW+1)'(tcc_pkg::TAB_STEP);
  assign cur_addr  = AW'(row_r) * AW'(tcc_pkg::COLS) + AW'(col_r);

  // cursor update
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.scroll_fix) begin
      row_nxt = RW'(tcc_pkg::ROWS - 1);
    end else if (cmd.put_exec) begin
      if (printable) begin
        if (col_inc >= (CW+1)'(tcc_pkg::COLS)) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end else if (code_r == tcc_pkg::CH_BS) begin
        if (col_r != '0) col_nxt = col_r - CW'(1);
      end else if (code_r == tcc_pkg::CH_TAB) begin
        if (col_tab >= (CW+1)'(tcc_pkg::COLS)) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_tab[CW-1:0];
        end
      end else if (code_r == tcc_pkg::CH_LF) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end
    end
  end

  // single write port: copy pipeline, space fill, or put
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = tcc_pkg::CH_SPACE;
    if (cp_wr_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_addr_r;
      wr_data = rd_data_r;
    end else if (cmd.fill_step) begin
      wr_en = 1'b1;
    end else if (cmd.put_exec && printable) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
      wr_data = code_r;
    end
  end

  assign rd_en   = cmd.scroll_step || (cmd.read_cell && in_range_r);
  assign rd_addr = cmd.scroll_step ? cnt_r + AW'(tcc_pkg::COLS) : rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      cp_wr_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cp_wr_r <= cmd.scroll_step;
      if (cmd.scroll_step) begin
        cnt_r <= stat.scroll_last ? '0 : cnt_r + AW'(1);
      end else if (cmd.fill_step) begin
        cnt_r <= stat.fill_last ? '0 : cnt_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cnt_r;
    if (cmd.latch) begin
      req_r      <= in_req_type;
      code_r     <= in_char_code;
      in_range_r <= (in_cell_row < RW'(tcc_pkg::ROWS)) && (in_cell_col < CW'(tcc_pkg::COLS));
      rd_addr_r  <= AW'(in_cell_row) * AW'(tcc_pkg::COLS) + AW'(in_cell_col);
    end
    if (cmd.load_out) begin
      out_cell_r <= (req_r == tcc_pkg::REQ_READ && in_range_r) ? rd_data_r : '0;
      out_col_r  <= col_r;
      out_row_r  <= row_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives put, clear, read and unused requests through the valid/stall
// input channel with random gaps and output stalls. A screen tracker
// predicts the cell character and cursor for every word and checks each
// returned word in order. The random part runs text lines, newline and
// tab runs, backspaces, noise bytes and reads, so the cursor wraps,
// scrolls and gets cleared many times.
// ---------------------------------------------------------------------------
module testbench;
  import tcc_pkg::*;

  localparam logic [1:0] REQ_NONE    = 2'd3;  // unused code, reports cursor only
  localparam int         ITEM_TARGET = 2000;
  localparam int         CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [CHAR_W-1:0] char_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_word_t;

  class screen_tracker;
    logic [CHAR_W-1:0] cells [ROWS][COLS];
    int                col_now;
    int                row_now;
    console_word_t     pending_words [$];
    int                errors;
    int                words;
    int                scrolls;
    int                clears;
    int                reads;

    function new();
      foreach (cells[r, c]) cells[r][c] = CH_SPACE;
      col_now = 0;
      row_now = 0;
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on word %0d: %0s got 0x%0h expected 0x%0h", words, what, got, want);
      errors++;
    endtask

    function void note_request(logic [1:0] kind, logic [CHAR_W-1:0] code,
                               logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
      console_word_t w;
      w = '0;
      case (kind)
        REQ_PUT: begin
          // a pending row is resolved by any put, even an ignored byte
          if (row_now >= ROWS) begin
            for (int r = 0; r < ROWS - 1; r++) cells[r] = cells[r + 1];
            row_now = ROWS - 1;
            scrolls++;
          end
          if (code >= CH_SPACE && code <= CH_TILDE) begin
            cells[row_now][col_now] = code;
            col_now++;
            if (col_now >= COLS) begin
              col_now = 0;
              row_now++;
            end
          end else if (code == CH_BS) begin
            if (col_now != 0) col_now--;
          end else if (code == CH_TAB) begin
            col_now += TAB_STEP;
            if (col_now >= COLS) begin
              col_now = 0;
              row_now++;
            end
          end else if (code == CH_LF) begin
            col_now = 0;
            row_now++;
          end
        end
        REQ_CLEAR: begin
          foreach (cells[r, c]) cells[r][c] = CH_SPACE;
          col_now = 0;
          row_now = 0;
          clears++;
        end
        REQ_READ: begin
          reads++;
          if (rrow < ROWS && rcol < COLS) w.char_val = cells[rrow][rcol];
        end
        default: ;
      endcase
      w.col = COL_W'(col_now);
      w.row = ROW_W'(row_now);
      pending_words.push_back(w);
    endfunction

    task check_word(logic [CHAR_W-1:0] ch, logic [COL_W-1:0] c,
                    logic [ROW_W-1:0] r);
      console_word_t want;
      words++;
      if (pending_words.size() == 0) begin
        report("word with nothing outstanding, cell_char", ch, 0);
        return;
      end
      want = pending_words.pop_front();
      if (ch !== want.char_val) report("cell_char", ch, want.char_val);
      if (c !== want.col) report("cursor_col", c, want.col);
      if (r !== want.row) report("cursor_row", r, want.row);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = REQ_PUT;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [ROW_W-1:0]  in_cell_row = '0;
  logic [COL_W-1:0]  in_cell_col = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] out_cell_char;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;

  screen_tracker screen = new();
  int            sent = 0;
  int            cycles = 0;
  bit            steady = 1'b0;  // both sides run without gaps while set

  text_console_cursor_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_char  (out_cell_char),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               screen.pending_words.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      screen.check_word(out_cell_char, out_cursor_col, out_cursor_row);
  end

  // receiver: random stall before each word
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge; valid stays high into the next call
  task automatic send_request(input logic [1:0] kind, input logic [CHAR_W-1:0] code,
                              input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_char_code <= code;
    in_cell_row  <= rrow;
    in_cell_col  <= rcol;
    do @(posedge clk); while (in_stall);
    screen.note_request(kind, code, rrow, rcol);
    sent++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] code);
    send_request(REQ_PUT, code, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_at(input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
    send_request(REQ_READ, CHAR_W'($urandom), rrow, rcol);
  endtask

  initial begin
    int pick;
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: printable limits, ignored bytes, cursor controls, reads
    read_at(0, 0);
    put_char(CH_TILDE);
    put_char(CH_SPACE);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'h1f);
    put_char(8'h7f);
    put_char(8'hff);
    put_char(CH_BS);
    read_at(0, 2);
    put_char(CH_TAB);
    put_char(CH_LF);
    put_char(CH_BS);        // already at column 0
    read_at(0, 0);
    read_at(24, 79);
    read_at(25, 0);         // past the last row
    read_at(0, 80);         // past the last column
    read_at(31, 127);
    send_request(REQ_NONE, 8'hff, 5'h1f, 7'h7f);
    send_request(REQ_CLEAR, 8'h41, 0, 0);
    read_at(0, 0);

    while (sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1, 2, 3, 4, 5, 6, 7: begin
          n = $urandom_range(1, 30);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0: put_char(CH_BS);
              1: put_char(CH_TAB);
              default: put_char(CHAR_W'($urandom_range(CH_SPACE, CH_TILDE)));
            endcase
          end
          if ($urandom_range(0, 3) != 0) put_char(CH_LF);
        end
        8, 9: repeat ($urandom_range(1, 8)) put_char(CH_LF);
        10: repeat ($urandom_range(1, 24)) put_char(CH_TAB);
        11, 12: repeat ($urandom_range(1, 4)) put_char(CHAR_W'($urandom));
        13, 14, 15, 16: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
              read_at(ROW_W'($urandom), COL_W'($urandom));
            else
              read_at(ROW_W'($urandom_range(0, ROWS - 1)),
                      COL_W'($urandom_range(0, COLS - 1)));
          end
        end
        17: begin
          if ($urandom_range(0, 2) == 0)
            send_request(REQ_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
          else
            send_request(REQ_NONE, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end
        18: repeat ($urandom_range(1, 6)) put_char(CH_BS);
        default: begin
          // long line without newline: can run past the last column and wrap
          repeat ($urandom_range(75, 95))
            put_char(CHAR_W'($urandom_range(CH_SPACE, CH_TILDE)));
        end
      endcase
    end

    in_valid <= 1'b0;
    steady = 1'b0;
    while (screen.pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests: %0d reads, %0d scrolls, %0d clears.", sent,
             screen.reads, screen.scrolls, screen.clears);
    $display("Checked %0d result words, %0d mismatches.", screen.words, screen.errors);
    if (screen.errors == 0 && screen.pending_words.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
